// File: hw/rtl/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// Shared constants, types and step functions of the Fresnel reflect/refract
// block.
// ----------------------------------------------------------------------------
package frr_pkg;

  localparam int IN_W   = 224;
  localparam int OUT_W  = 176;
  localparam int IDX_W  = 14;
  localparam int ETA_W  = 20;

  localparam logic [IDX_W-1:0] OUTSIDE_RST = 14'd4096;
  localparam logic [IDX_W-1:0] INSIDE_RST  = 14'd6554;

  typedef enum logic [0:0] {
    REG_OUTSIDE = 1'b0,
    REG_INSIDE  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] n_out;
    logic [IDX_W-1:0] n_in;
    logic [ETA_W-1:0] eta_ent;
    logic [ETA_W-1:0] eta_ext;
    logic [ETA_W-1:0] w_ent;
    logic [ETA_W-1:0] w_ext;
  } coef_t;

  // Pipeline stage map.
  localparam int ST_PROD    = 0;
  localparam int ST_DOT     = 1;
  localparam int ST_SQ_IN   = 2;
  localparam int ST_R       = 3;
  localparam int ST_RSQ     = 4;
  localparam int ST_LEN2    = 5;
  localparam int ST_SQ1     = 6;
  localparam int SQ1_N      = 23;
  localparam int ST_SINT    = ST_SQ1 + SQ1_N;
  localparam int ST_COST_IN = ST_SINT + 1;
  localparam int ST_SQ2     = ST_COST_IN + 1;
  localparam int SQ2_N      = 17;
  localparam int ST_FRES    = ST_SQ2 + SQ2_N;
  localparam int ST_REFR    = ST_FRES + 1;
  localparam int ST_DIV     = ST_REFR + 1;
  localparam int DIV_N      = 17;
  localparam int ST_FR      = ST_DIV + DIV_N;
  localparam int ST_SEL     = ST_FR + 1;
  localparam int N_STG      = ST_SEL + 1;

  typedef struct packed {
    logic [47:0] x;
    logic [47:0] r;
  } sq_t;

  typedef struct packed {
    logic [47:0] rem;
    logic [16:0] q;
  } dv_t;

  // One step of the digit-by-digit square root, trial bit 4**e.
  function automatic sq_t sqrt_step(sq_t s, int e);
    logic [47:0] b;
    logic [47:0] t;
    sq_t         o;
    b = 48'd1 << (2 * e);
    t = s.r + b;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // One restoring division step producing quotient bit sh.
  function automatic dv_t div_step(dv_t s, logic [31:0] den, int sh);
    logic [47:0] t;
    dv_t         o;
    t = {16'd0, den} << sh;
    o = s;
    if (s.rem >= t) begin
      o.rem = s.rem - t;
      o.q   = s.q | (17'd1 << sh);
    end
    return o;
  endfunction

  function automatic logic [17:0] sat18(logic signed [47:0] v);
    if (v > 48'sd131071) begin
      return 18'h1FFFF;
    end else if (v < -48'sd131072) begin
      return 18'h20000;
    end else begin
      return v[17:0];
    end
  endfunction

endpackage

// File: hw/rtl/frr_coef.sv
// ----------------------------------------------------------------------------
// frr_coef
// Index registers and the per-direction ratio and weight, recomputed by a
// shared serial divider after reset and after every register write.
// ----------------------------------------------------------------------------
module frr_coef (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  frr_pkg::cfg_reg_t           cfg_addr,
  input  logic [frr_pkg::IDX_W-1:0]   cfg_wdata,
  output frr_pkg::coef_t              coef
);
  import frr_pkg::*;

  localparam int          DVD_W = 44;
  localparam int          DVS_W = 28;
  localparam logic [5:0]  LAST_STEP = 6'(DVD_W - 1);

  typedef enum logic [1:0] {C_IDLE, C_LOAD, C_RUN} cstate_t;

  cstate_t            state_r;
  logic [1:0]         job_r;
  logic [5:0]         cnt_r;
  logic [IDX_W-1:0]   out_r, in_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [DVS_W-1:0]   rem_r;
  logic [DVD_W-1:0]   quo_r;
  logic [ETA_W-1:0]   eta_ent_r, eta_ext_r, w_ent_r, w_ext_r;

  logic [IDX_W-1:0]   no, ni;
  logic [DVS_W-1:0]   no_sq, ni_sq;
  logic [DVS_W:0]     rem_sh;
  logic               ge;
  logic [DVS_W-1:0]   rem_nxt;
  logic [DVD_W-1:0]   quo_nxt;
  logic [ETA_W-1:0]   res_sat;

  always_comb begin
    no      = (out_r == '0) ? IDX_W'(1) : out_r;
    ni      = (in_r == '0) ? IDX_W'(1) : in_r;
    no_sq   = {14'd0, no} * {14'd0, no};
    ni_sq   = {14'd0, ni} * {14'd0, ni};
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], ge};
    res_sat = (quo_nxt[DVD_W-1:ETA_W] != '0) ? {ETA_W{1'b1}} : quo_nxt[ETA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_LOAD;
      job_r   <= '0;
      cnt_r   <= '0;
      out_r   <= OUTSIDE_RST;
      in_r    <= INSIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OUTSIDE: out_r <= cfg_wdata;
        REG_INSIDE:  in_r  <= cfg_wdata;
        default:     out_r <= out_r;
      endcase
      state_r <= C_LOAD;
      job_r   <= '0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          state_r <= C_IDLE;
        end
        C_LOAD: begin
          unique case (job_r)
            2'd0: begin
              dvd_r <= {14'd0, no, 16'd0};
              dvs_r <= {14'd0, ni};
            end
            2'd1: begin
              dvd_r <= {14'd0, ni, 16'd0};
              dvs_r <= {14'd0, no};
            end
            2'd2: begin
              dvd_r <= {ni_sq, 16'd0};
              dvs_r <= no_sq;
            end
            default: begin
              dvd_r <= {no_sq, 16'd0};
              dvs_r <= ni_sq;
            end
          endcase
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= C_RUN;
        end
        C_RUN: begin
          dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == LAST_STEP) begin
            unique case (job_r)
              2'd0:    eta_ent_r <= res_sat;
              2'd1:    eta_ext_r <= res_sat;
              2'd2:    w_ent_r   <= res_sat;
              default: w_ext_r   <= res_sat;
            endcase
            job_r   <= job_r + 2'd1;
            state_r <= (job_r == 2'd3) ? C_IDLE : C_LOAD;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign coef = '{busy:    (state_r != C_IDLE),
                  n_out:   no,
                  n_in:    ni,
                  eta_ent: eta_ent_r,
                  eta_ext: eta_ext_r,
                  w_ent:   w_ent_r,
                  w_ext:   w_ext_r};

endmodule

// File: hw/rtl/fresnel_reflect_refract.sv
// ----------------------------------------------------------------------------
// fresnel_reflect_refract
// Chooses the mirror or the refracted direction of a dielectric ray hit by
// its Fresnel reflectance against a random number.
//
//   Group  Direction  Contents
//   in_    slave      direction, normal, hit point, random number
//   out_   master     origin, new direction, weight; tuser marks reflection
//   cfg_   write      outer and inner refractive index
//
// A transfer enters every cycle unless a result waits untaken at the output,
// the divider is busy or a register is written; the pipeline holds 69 items
// at most. After reset and after each register write the input takes no
// transfer while a serial divider forms the index ratios and weights.
// A result that is not taken holds the whole pipeline in place.
// ----------------------------------------------------------------------------
module fresnel_reflect_refract (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, hit_x, hit_y, hit_z,
  // chance
  input  logic [frr_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // origin_x, origin_y, origin_z, out_x, out_y, out_z, weight
  output logic [frr_pkg::OUT_W-1:0]   out_tdata,
  // reflected
  output logic                        out_tuser,
  input  logic                        cfg_we,
  input  frr_pkg::cfg_reg_t           cfg_addr,
  input  logic [frr_pkg::IDX_W-1:0]   cfg_wdata
);
  import frr_pkg::*;

  typedef struct packed {
    logic [2:0][17:0]    d;
    logic [2:0][17:0]    n;
    logic [2:0][31:0]    hit;
    logic [15:0]         chance;
    logic [2:0][35:0]    p;
    logic signed [37:0]  dot;
    logic                exiting;
    logic [16:0]         cosi;
    logic signed [21:0]  dot16;
    logic [IDX_W-1:0]    etai;
    logic [IDX_W-1:0]    etat;
    logic [ETA_W-1:0]    eta;
    logic [ETA_W-1:0]    wgt;
    logic [2:0][41:0]    m;
    logic [36:0]         ec;
    logic [2:0][23:0]    r;
    logic [2:0][47:0]    rsq;
    sq_t                 sa;
    sq_t                 sl;
    sq_t                 sc;
    logic [20:0]         sint;
    logic                tir;
    logic [23:0]         len;
    dv_t [2:0]           dm;
    logic [16:0]         cost;
    logic signed [22:0]  k;
    logic [2:0][17:0]    om;
    logic [31:0]         den_a;
    logic [31:0]         den_e;
    dv_t                 da;
    dv_t                 de;
    logic [2:0][38:0]    ed;
    logic [2:0][41:0]    kn;
    logic [2:0][17:0]    orf;
    logic [32:0]         rpa2;
    logic [32:0]         rpe2;
    logic                refl;
    logic [2:0][17:0]    o;
  } item_t;

  coef_t             coef;
  item_t             pipe_r [N_STG];
  item_t             nxt    [N_STG];
  logic [N_STG-1:0]  vld_r;
  logic              en;
  logic              in_fire;

  frr_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  assign en        = !vld_r[N_STG-1] || out_tready;
  assign in_tready = en && !coef.busy && !cfg_we;
  assign in_fire   = in_tvalid && in_tready;

  for (genvar k = 0; k < N_STG; k++) begin : g_stg
    if (k == ST_PROD) begin : g_prod
      always_comb begin
        item_t it;
        it = '0;
        for (int i = 0; i < 3; i++) begin
          it.d[i]   = in_tdata[18*i +: 18];
          it.n[i]   = in_tdata[54 + 18*i +: 18];
          it.hit[i] = in_tdata[108 + 32*i +: 32];
          it.p[i]   = $signed(it.d[i]) * $signed(it.n[i]);
        end
        it.chance = in_tdata[204 +: 16];
        nxt[k] = it;
      end
    end else if (k == ST_DOT) begin : g_dot
      always_comb begin
        item_t             it;
        logic signed [38:0] dx;
        logic signed [38:0] t;
        it = pipe_r[k-1];
        it.dot = $signed(it.p[0]) + $signed(it.p[1]) + $signed(it.p[2]);
        it.exiting = (it.dot > 38'sd0);
        dx = it.dot;
        if (!it.exiting) begin
          dx = -dx;
        end
        dx = (dx + 39'sd32768) >>> 16;
        it.cosi = (dx > 39'sd65536) ? 17'h10000 : dx[16:0];
        t = it.dot;
        t = (t + 39'sd32768) >>> 16;
        it.dot16 = t[21:0];
        it.etai = it.exiting ? coef.n_in : coef.n_out;
        it.etat = it.exiting ? coef.n_out : coef.n_in;
        it.eta  = it.exiting ? coef.eta_ext : coef.eta_ent;
        it.wgt  = it.exiting ? coef.w_ext : coef.w_ent;
        nxt[k] = it;
      end
    end else if (k == ST_SQ_IN) begin : g_sqin
      always_comb begin
        item_t              it;
        logic signed [41:0] dd;
        logic signed [41:0] nv;
        it = pipe_r[k-1];
        dd = it.dot16;
        for (int i = 0; i < 3; i++) begin
          nv = $signed(it.n[i]);
          it.m[i] = (dd * nv) <<< 1;
        end
        it.ec   = {17'd0, it.eta} * {20'd0, it.cosi};
        it.sa.x = 48'h1_0000_0000 - ({31'd0, it.cosi} * {31'd0, it.cosi});
        it.sa.r = '0;
        nxt[k] = it;
      end
    end else if (k == ST_R) begin : g_r
      always_comb begin
        item_t              it;
        logic signed [41:0] mm;
        logic signed [41:0] dv;
        it = pipe_r[k-1];
        for (int i = 0; i < 3; i++) begin
          mm = $signed(it.m[i]);
          mm = (mm + 42'sd32768) >>> 16;
          dv = $signed(it.d[i]);
          dv = dv - mm;
          it.r[i] = dv[23:0];
        end
        nxt[k] = it;
      end
    end else if (k == ST_RSQ) begin : g_rsq
      always_comb begin
        item_t              it;
        logic signed [47:0] rv;
        it = pipe_r[k-1];
        for (int i = 0; i < 3; i++) begin
          rv = $signed(it.r[i]);
          rv = rv * rv;
          it.rsq[i] = rv;
        end
        nxt[k] = it;
      end
    end else if (k == ST_LEN2) begin : g_len2
      always_comb begin
        item_t it;
        it = pipe_r[k-1];
        it.sl.x = it.rsq[0] + it.rsq[1] + it.rsq[2];
        it.sl.r = '0;
        nxt[k] = it;
      end
    end else if (k >= ST_SQ1 && k < ST_SQ1 + SQ1_N) begin : g_sq1
      always_comb begin
        item_t it;
        it = pipe_r[k-1];
        it.sa = sqrt_step(it.sa, SQ1_N - 1 - (k - ST_SQ1));
        it.sl = sqrt_step(it.sl, SQ1_N - 1 - (k - ST_SQ1));
        nxt[k] = it;
      end
    end else if (k == ST_SINT) begin : g_sint
      always_comb begin
        item_t       it;
        logic [37:0] t;
        it = pipe_r[k-1];
        t = {18'd0, it.eta} * {21'd0, it.sa.r[16:0]} + 38'd32768;
        it.sint = t[36:16];
        it.tir  = (it.sint[20:16] != '0);
        nxt[k] = it;
      end
    end else if (k == ST_COST_IN) begin : g_costin
      always_comb begin
        item_t       it;
        logic [23:0] a;
        it = pipe_r[k-1];
        it.sc.x = 48'h1_0000_0000 - ({32'd0, it.sint[15:0]} * {32'd0, it.sint[15:0]});
        it.sc.r = '0;
        it.len  = it.sl.r[23:0];
        for (int i = 0; i < 3; i++) begin
          a = it.r[i][23] ? (24'd0 - it.r[i]) : it.r[i];
          it.dm[i].rem = ({24'd0, a} << 16) + {25'd0, it.len[23:1]};
          it.dm[i].q   = '0;
        end
        nxt[k] = it;
      end
    end else if (k >= ST_SQ2 && k < ST_SQ2 + SQ2_N) begin : g_sq2
      always_comb begin
        item_t it;
        it = pipe_r[k-1];
        it.sc = sqrt_step(it.sc, SQ2_N - 1 - (k - ST_SQ2));
        for (int i = 0; i < 3; i++) begin
          it.dm[i] = div_step(it.dm[i], {8'd0, it.len}, DIV_N - 1 - (k - ST_SQ2));
        end
        nxt[k] = it;
      end
    end else if (k == ST_FRES) begin : g_fres
      always_comb begin
        item_t       it;
        logic [31:0] tci, ict, ici, tct;
        logic [36:0] t;
        logic [17:0] q;
        it = pipe_r[k-1];
        it.cost = it.sc.r[16:0];
        tci = {18'd0, it.etat} * {15'd0, it.cosi};
        ict = {18'd0, it.etai} * {15'd0, it.cost};
        ici = {18'd0, it.etai} * {15'd0, it.cosi};
        tct = {18'd0, it.etat} * {15'd0, it.cost};
        it.den_a  = tci + ict;
        it.den_e  = ici + tct;
        it.da.rem = {(tci >= ict) ? (tci - ict) : (ict - tci), 16'd0};
        it.da.q   = '0;
        it.de.rem = {(ici >= tct) ? (ici - tct) : (tct - ici), 16'd0};
        it.de.q   = '0;
        t = it.ec + 37'd32768;
        it.k = $signed({2'b00, t[36:16]}) - $signed({6'd0, it.cost});
        for (int i = 0; i < 3; i++) begin
          q = {1'b0, it.dm[i].q};
          if (it.len == '0) begin
            it.om[i] = '0;
          end else begin
            it.om[i] = it.r[i][23] ? (18'd0 - q) : q;
          end
        end
        nxt[k] = it;
      end
    end else if (k == ST_REFR) begin : g_refr
      always_comb begin
        item_t              it;
        logic signed [38:0] ev;
        logic signed [38:0] dv;
        logic signed [41:0] kv;
        logic signed [41:0] nv;
        it = pipe_r[k-1];
        ev = $signed({19'd0, it.eta});
        kv = it.k;
        for (int i = 0; i < 3; i++) begin
          dv = $signed(it.d[i]);
          it.ed[i] = ev * dv;
          nv = $signed(it.n[i]);
          if (it.exiting) begin
            nv = -nv;
          end
          it.kn[i] = kv * nv;
        end
        nxt[k] = it;
      end
    end else if (k >= ST_DIV && k < ST_DIV + DIV_N) begin : g_div
      always_comb begin
        item_t it;
        it = pipe_r[k-1];
        it.da = div_step(it.da, it.den_a, DIV_N - 1 - (k - ST_DIV));
        it.de = div_step(it.de, it.den_e, DIV_N - 1 - (k - ST_DIV));
        nxt[k] = it;
      end
    end else if (k == ST_FR) begin : g_fr
      always_comb begin
        item_t              it;
        logic [16:0]        pa, pe;
        logic signed [47:0] s;
        it = pipe_r[k-1];
        pa = (it.den_a == '0) ? 17'h10000 : it.da.q;
        pe = (it.den_e == '0) ? 17'h10000 : it.de.q;
        it.rpa2 = {16'd0, pa} * {16'd0, pa};
        it.rpe2 = {16'd0, pe} * {16'd0, pe};
        for (int i = 0; i < 3; i++) begin
          s = $signed(it.ed[i]);
          s = s + $signed(it.kn[i]);
          s = (s + 48'sd32768) >>> 16;
          it.orf[i] = sat18(s);
        end
        nxt[k] = it;
      end
    end else begin : g_sel
      always_comb begin
        item_t       it;
        logic [33:0] sum;
        logic [16:0] fr;
        it = pipe_r[k-1];
        sum = {1'b0, it.rpa2} + {1'b0, it.rpe2};
        fr = it.tir ? 17'h10000 : sum[33:17];
        it.refl = ({1'b0, it.chance} <= fr);
        it.o = it.refl ? it.om : it.orf;
        nxt[k] = it;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_STG-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= nxt;
    end
  end

  assign out_tvalid = vld_r[N_STG-1];
  assign out_tuser  = pipe_r[N_STG-1].refl;
  assign out_tdata  = {6'd0,
                       pipe_r[N_STG-1].wgt,
                       pipe_r[N_STG-1].o[2],
                       pipe_r[N_STG-1].o[1],
                       pipe_r[N_STG-1].o[0],
                       pipe_r[N_STG-1].hit[2],
                       pipe_r[N_STG-1].hit[1],
                       pipe_r[N_STG-1].hit[0]};

`ifndef SYNTHESIS
  a_tir_reflects: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N_STG-1] && pipe_r[N_STG-1].tir |-> out_tuser)
    else $error("total internal reflection did not pick the mirror direction");

  a_cfg_recompute: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> coef.busy)
    else $error("register write did not start the coefficient update");

  a_mirror_unit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N_STG-1] && out_tuser |->
      ($signed(pipe_r[N_STG-1].o[0]) <= 18'sd65536) &&
      ($signed(pipe_r[N_STG-1].o[0]) >= -18'sd65536) &&
      ($signed(pipe_r[N_STG-1].o[2]) <= 18'sd65536) &&
      ($signed(pipe_r[N_STG-1].o[2]) >= -18'sd65536))
    else $error("mirror direction component exceeds unit length");
`endif

endmodule
